[hdl/tmtw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_pkg: shared types and constants of the text mode terminal writer
// Item formats, codes, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package tmtw_pkg;

	// Default screen geometry.
	localparam int ROWS_DEF      = 25;
	localparam int COLS_DEF      = 80;
	localparam int TAB_WIDTH_DEF = 8;

	// Fixed field widths.
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;
	localparam int CELL_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FORE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK = 1'b1;

	// Item kinds.
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_MOVE  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;

	// Colour reset values and the blank cell that reset leaves behind.
	localparam logic [3:0] FORE_RESET = 4'd7;
	localparam logic [3:0] BACK_RESET = 4'd0;
	localparam logic [CELL_W-1:0] BLANK_RESET = {BACK_RESET, FORE_RESET, CH_SPACE};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_code;
		logic [7:0] target_row;
		logic [7:0] target_col;
	} item_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [COL_OUT_W-1:0] cursor_col;
		logic [CELL_W-1:0]    cell_value;
		logic                 did_scroll;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;       // apply the item on the input
		logic sweep;      // write one blank cell of the running sweep
		logic init_fill;  // sweep writes the reset blank cell
		logic load_cell;  // capture the memory read data into the result
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
		logic needs_sweep;
		logic sweep_last;
	} dp_stat_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SWEEP
	} state_t;

endpackage

[hdl/tmtw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmtw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/tmtw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_ctrl: controller of the text mode terminal writer
// Sequences item acceptance, memory sweeps, cell reads and the result slot.
// ----------------------------------------------------------------------------
module tmtw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tmtw_pkg::dp_stat_t stat,
	output tmtw_pkg::ctl_cmd_t cmd
);
	import tmtw_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q, out_valid_n;
	logic   set_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		set_out  = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep     = 1'b1;
				cmd.init_fill = 1'b1;
				if (stat.sweep_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				cmd.take = in_valid && in_ready;
				if (cmd.take) begin
					if (stat.is_read) begin
						state_n = ST_READ;
					end else if (stat.needs_sweep) begin
						state_n = ST_SWEEP;
					end else begin
						set_out = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.load_cell = 1'b1;
				set_out       = 1'b1;
				state_n       = ST_IDLE;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					set_out = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_INIT;
			end
		endcase
		out_valid_n = set_out || (out_valid_q && !out_ready);
	end

	assign out_valid = out_valid_q;

	// The result slot is empty for the whole of any sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP || state_q == ST_INIT) |-> !out_valid_q)
		else $error("result pending during a memory sweep");

	// A read item presents its result in the cycle after its ST_READ cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("read result not presented after read cycle");

	// Items that need no sweep and no read have their result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && !stat.is_read && !stat.needs_sweep) |=>
		(out_valid_q && state_q == ST_IDLE))
		else $error("single-cycle item did not produce a result");

endmodule

[hdl/tmtw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_dp: datapath of the text mode terminal writer
// Cursor, ring offset, colours, screen memory, sweep counter and result.
// ----------------------------------------------------------------------------
module tmtw_dp #(
	parameter int ROWS      = tmtw_pkg::ROWS_DEF,
	parameter int COLS      = tmtw_pkg::COLS_DEF,
	parameter int TAB_WIDTH = tmtw_pkg::TAB_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tmtw_pkg::item_t                   in_data,
	input  tmtw_pkg::ctl_cmd_t                cmd,
	output tmtw_pkg::dp_stat_t                stat,
	input  logic                              cfg_we,
	input  logic [tmtw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmtw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tmtw_pkg::res_t                    res
);
	import tmtw_pkg::*;

	localparam int RW      = $clog2(ROWS);
	localparam int CW      = $clog2(COLS);
	localparam int CELLS   = ROWS * COLS;
	localparam int AW      = $clog2(CELLS);
	localparam int RSH     = 16;
	localparam int RECIP_W = RSH + 1;
	localparam int RECIP   = ((1 << RSH) + TAB_WIDTH - 1) / TAB_WIDTH;
	localparam int PW      = CW + RECIP_W;
	localparam int NCW     = CW + $clog2(TAB_WIDTH) + 1;

	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

	logic [RW-1:0]         cur_row_q, top_q, row_n, top_n, tr_c;
	logic [CW-1:0]         cur_col_q, col_n, tc_c, tab_col;
	logic [CW:0]           col_inc;
	logic [3:0]            fore_q, back_q;
	logic [AW-1:0]         base_q, cnt_q, last_q;
	logic [PW-1:0]         tab_prod;
	logic [CW:0]           tab_quo;
	logic [NCW-1:0]        tab_nc;
	logic                  do_lf, scroll, we_put, is_clear;
	logic [7:0]            attr;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, put_addr, rd_addr;
	logic [CELL_W-1:0]     ram_wdata, ram_rdata;
	res_t                  res_q;

	// Logical row r lives in physical row (top + r) mod ROWS.
	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] top,
		input logic [RW-1:0] r, input logic [CW-1:0] c);
		logic [RW:0] sum;
		sum = {1'b0, top} + {1'b0, r};
		if (sum >= (RW+1)'(ROWS)) begin
			sum = sum - (RW+1)'(ROWS);
		end
		return AW'(sum[RW-1:0]) * AW'(COLS) + AW'(c);
	endfunction

	assign tr_c = (in_data.target_row > 8'(ROWS - 1)) ? LAST_ROW : in_data.target_row[RW-1:0];
	assign tc_c = (in_data.target_col > 8'(COLS - 1)) ? LAST_COL : in_data.target_col[CW-1:0];
	assign attr = {back_q, fore_q};

	// Next tab stop: quotient by reciprocal multiplication, exact for these widths.
	assign tab_prod = PW'(cur_col_q) * PW'(RECIP);
	assign tab_quo  = tab_prod[PW-1:RSH];
	assign tab_nc   = (NCW'(tab_quo) + NCW'(1)) * NCW'(TAB_WIDTH);
	assign tab_col  = (tab_nc > NCW'(COLS - 1)) ? LAST_COL : tab_nc[CW-1:0];

	assign put_addr = cell_addr(top_q, cur_row_q, cur_col_q);
	assign rd_addr  = cell_addr(top_q, tr_c, tc_c);

	always_comb begin
		row_n    = cur_row_q;
		col_n    = cur_col_q;
		top_n    = top_q;
		do_lf    = 1'b0;
		scroll   = 1'b0;
		we_put   = 1'b0;
		is_clear = 1'b0;
		col_inc  = {1'b0, cur_col_q} + (CW+1)'(1);
		case (in_data.kind)
			KIND_PUT: begin
				if (in_data.char_code == CH_LF) begin
					do_lf = 1'b1;
				end else if (in_data.char_code == CH_TAB) begin
					col_n = tab_col;
				end else begin
					we_put = 1'b1;
					if (col_inc >= (CW+1)'(COLS)) begin
						do_lf = 1'b1;
					end else begin
						col_n = col_inc[CW-1:0];
					end
				end
			end
			KIND_MOVE: begin
				row_n = tr_c;
				col_n = tc_c;
			end
			KIND_CLEAR: begin
				is_clear = 1'b1;
				row_n    = '0;
				col_n    = '0;
				top_n    = '0;
			end
			KIND_READ: begin
			end
			default: begin
			end
		endcase
		if (do_lf) begin
			col_n = '0;
			if (cur_row_q != LAST_ROW) begin
				row_n = cur_row_q + RW'(1);
			end else begin
				scroll = 1'b1;
				top_n  = (top_q == LAST_ROW) ? '0 : top_q + RW'(1);
			end
		end
	end

	assign stat.is_read     = (in_data.kind == KIND_READ);
	assign stat.needs_sweep = is_clear || scroll;
	assign stat.sweep_last  = (cnt_q == last_q);

	always_comb begin
		if (cmd.sweep) begin
			ram_we    = 1'b1;
			ram_waddr = base_q + cnt_q;
			ram_wdata = cmd.init_fill ? BLANK_RESET : {attr, CH_SPACE};
		end else begin
			ram_we    = cmd.take && we_put;
			ram_waddr = put_addr;
			ram_wdata = {attr, in_data.char_code};
		end
	end

	tmtw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.take),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			top_q     <= '0;
			fore_q    <= FORE_RESET;
			back_q    <= BACK_RESET;
			base_q    <= '0;
			cnt_q     <= '0;
			last_q    <= AW'(CELLS - 1);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FORE: fore_q <= cfg_data;
					REG_BACK: back_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.take) begin
				cur_row_q <= row_n;
				cur_col_q <= col_n;
				top_q     <= top_n;
				if (is_clear) begin
					base_q <= '0;
					cnt_q  <= '0;
					last_q <= AW'(CELLS - 1);
				end else if (scroll) begin
					// The row that becomes the last one is the old top row.
					base_q <= AW'(top_q) * AW'(COLS);
					cnt_q  <= '0;
					last_q <= AW'(COLS - 1);
				end
			end else if (cmd.sweep && (cnt_q != last_q)) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			res_q.cursor_row <= ROW_OUT_W'(row_n);
			res_q.cursor_col <= COL_OUT_W'(col_n);
			res_q.cell_value <= '0;
			res_q.did_scroll <= scroll;
		end else if (cmd.load_cell) begin
			res_q.cell_value <= ram_rdata;
		end
	end

	assign res = res_q;

	// The sweep counter never runs past the end of its span.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= last_q)
		else $error("sweep counter beyond sweep end");

	// The cursor always lies on the screen.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q <= LAST_ROW) && (cur_col_q <= LAST_COL))
		else $error("cursor off screen");

	// A sweep never overlaps a put write from a new item.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.sweep |-> !cmd.take)
		else $error("item taken during a memory sweep");

endmodule

[hdl/text_mode_terminal_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer: character-cell console engine
// Keeps a ring-buffered screen of 16-bit cells and a cursor, and executes
// put, move, clear and read items, each returning one result item.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_valid/in_ready and results leave on out_valid/out_ready;
// every accepted item yields exactly one result item, in order. Colours are
// set through cfg_we/cfg_index/cfg_data, by the user only while the block is
// idle; the block itself does not enforce this. A put, tab, move or a line
// feed that does not scroll has its result in the cycle after acceptance; a
// read first takes one registered memory read; an item that scrolls first
// blanks the new bottom row one cell per cycle through the single memory
// write port, and a clear screen blanks all ROWS * COLS cells the same way.
// Plain characters are taken at one item per cycle while the result is taken
// each cycle and no item scrolls. After reset the block blanks all ROWS * COLS
// cells before it raises in_ready; configuration writes are taken during
// that time. The result sits in an output register: while a result is
// pending, the block still accepts one more item if that register is being
// emptied in the same cycle, and otherwise waits.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
	parameter int ROWS      = tmtw_pkg::ROWS_DEF,
	parameter int COLS      = tmtw_pkg::COLS_DEF,
	parameter int TAB_WIDTH = tmtw_pkg::TAB_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tmtw_pkg::item_t                 in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tmtw_pkg::res_t                  out_data,
	input  logic                            cfg_we,
	input  logic [tmtw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmtw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tmtw_pkg::*;

	// Command and status between the controller and the datapath.
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// The controller owns the handshakes, the result slot valid flag and the
	// sequencing of sweeps; it never looks at payload bits itself.
	tmtw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the cursor, ring offset, colours, screen memory and
	// the result register that drives out_data.
	tmtw_dp #(
		.ROWS     (ROWS),
		.COLS     (COLS),
		.TAB_WIDTH(TAB_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.res      (out_data)
	);

endmodule
